// ===== hw/rtl/hc_pkg.sv =====
// ----------------------------------------------------------------------------
// hc_pkg: shared definitions for the Hill cipher encryptor
// Op codes, sequencer states, the control word sent down the cell row, and the
// mod-26 reduction used for letters, key values and the row accumulators.
// ----------------------------------------------------------------------------
package hc_pkg;

  localparam int DEF_MAX_DIM = 8;

  localparam int SYM_W       = 5;   // one letter value, 0..25
  localparam int PROD_W      = 10;  // key entry times letter value
  localparam int RED_W       = 11;  // widest value fed to mod26()
  localparam int BSIZE_W     = 4;
  localparam int KIDX_W      = 3;   // key_row / key_col width
  localparam int KEY_VALUE_W = 30;
  localparam int LETTER_W    = 7;
  localparam int DIGIT_W     = 6;   // key value bits folded in per step
  localparam int NUM_DIGITS  = KEY_VALUE_W / DIGIT_W;
  localparam int KDIG_W      = 3;

  localparam logic [LETTER_W-1:0] CODE_A        = 7'd65;
  localparam logic [RED_W-1:0]    LETTER_OFFSET = 11'd13;  // (code + 13) mod 26
  localparam logic [SYM_W-1:0]    PAD_VALUE     = 5'd23;   // 'X'

  // 315 / 8192 sits just under 1/26, so the quotient is low by at most one
  localparam logic [19:0] RECIP_26 = 20'd315;
  localparam int          RECIP_SH = 13;

  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_LETTER = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;

  typedef logic [SYM_W-1:0] sym_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY,
    S_KEYWR,
    S_MUL,
    S_PAD,
    S_DRAIN,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic              key_we;
    logic [KIDX_W-1:0] key_row;
    sym_t              key_val;
    logic              mul_en;
    sym_t              letter;
    logic              acc_en;
    logic              acc_first;
    logic              load;
    logic              shift;
  } cell_ctl_t;

  // x mod 26 for x below 2048
  function automatic sym_t mod26(input logic [RED_W-1:0] x);
    logic [19:0] prod;
    logic [6:0]  quo;
    logic [11:0] rem;
    prod = 20'(x) * RECIP_26;
    quo  = prod[19:RECIP_SH];
    rem  = 12'(x) - 12'(quo) * 12'd26;
    if (rem >= 12'd26) begin
      rem = rem - 12'd26;
    end
    return rem[SYM_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/hc_cell.sv =====
// ----------------------------------------------------------------------------
// hc_cell: one row of the key matrix
// Holds its key row, multiplies the selected entry by the broadcast letter,
// keeps a mod-26 running dot product, and passes finished letters to its
// neighbor toward the output.
// ----------------------------------------------------------------------------
module hc_cell #(
  parameter int MAX_DIM = hc_pkg::DEF_MAX_DIM,
  parameter int ROW     = 0,
  localparam int PW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic              clk,
  input  hc_pkg::cell_ctl_t ctl,
  input  logic [PW-1:0]     idx,
  input  hc_pkg::sym_t      shift_in,
  output hc_pkg::sym_t      shift_out
);

  hc_pkg::sym_t                key [MAX_DIM];
  logic [hc_pkg::PROD_W-1:0]   prod;
  hc_pkg::sym_t                acc;
  hc_pkg::sym_t                held;
  logic                        row_hit;

  assign row_hit = (32'(ctl.key_row) == 32'(ROW));

  always_ff @(posedge clk) begin
    if (ctl.key_we && row_hit) begin
      key[idx] <= ctl.key_val;
    end
    if (ctl.mul_en) begin
      prod <= hc_pkg::PROD_W'(key[idx]) * hc_pkg::PROD_W'(ctl.letter);
    end
    if (ctl.acc_en) begin
      if (ctl.acc_first) begin
        acc <= hc_pkg::mod26(hc_pkg::RED_W'(prod));
      end else begin
        acc <= hc_pkg::mod26(hc_pkg::RED_W'(acc) + hc_pkg::RED_W'(prod));
      end
    end
    if (ctl.load) begin
      held <= acc;
    end else if (ctl.shift) begin
      held <= shift_in;
    end
  end

  assign shift_out = held;

endmodule

// ===== hw/rtl/hill_cipher_encrypt_top.sv =====
// ----------------------------------------------------------------------------
// hill_cipher_encrypt_top: Hill cipher encryptor over A-Z, modulo 26
// A row of MAX_DIM cells, one per key row, accumulates the cipher letters as
// plaintext letters arrive, then shifts the finished block out.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): one word per op. op 0 writes key entry
//   (key_row, key_col) = key_value mod 26; op 1 adds letter_code to the current
//   block; op 2 pads a partial block with X and flushes it; op 3 is dropped.
//   Output channel (out_valid/out_ready): one cipher letter per word, in row
//   order, block_last high on the final letter of a block.
//   cfg_we/cfg_data set block_size (0 acts as 1, above MAX_DIM as MAX_DIM) and
//   drop any partial block; write it only while the block is quiet.
// Sequencing
//   Letter: accepted in S_IDLE, then one multiply in every cell in S_MUL; the
//   add-and-reduce overlaps the next word. The letter that completes a block
//   also passes S_DRAIN and S_LOAD, and waits in S_LOAD while the output row
//   still holds the previous block. Key write: the 30-bit key value is reduced
//   mod 26 digit-serially in S_KEY, 6 bits a cycle, then written in S_KEYWR.
//   End with padding: S_PAD multiplies one pad letter a cycle, then drain and
//   load. A completed block shows its first letter once S_LOAD loads it.
// Reset clears the sequencer, the fill count and the output count and sets
// block_size to 1; key entries hold garbage until written.
// When the receiver stalls the block keeps taking words until the next block
// is done; that block then waits in the cells until the output row drains.
// ----------------------------------------------------------------------------
module hill_cipher_encrypt_top #(
  parameter int MAX_DIM = hc_pkg::DEF_MAX_DIM
) (
  input  logic                              clk,
  input  logic                              rst,
  // config
  input  logic                              cfg_we,
  input  logic [hc_pkg::BSIZE_W-1:0]        cfg_data,
  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        op,
  input  logic [hc_pkg::KIDX_W-1:0]         key_row,
  input  logic [hc_pkg::KIDX_W-1:0]         key_col,
  input  logic [hc_pkg::KEY_VALUE_W-1:0]    key_value,
  input  logic [hc_pkg::LETTER_W-1:0]       letter_code,
  // output words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hc_pkg::LETTER_W-1:0]       cipher_code,
  output logic                              block_last
);

  localparam int PW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;  // index into a key row
  localparam int NW = $clog2(MAX_DIM + 1);                  // counts up to MAX_DIM

  hc_pkg::state_t                  state, state_next;
  logic [hc_pkg::BSIZE_W-1:0]      bsize;
  logic [NW-1:0]                   fill;
  logic [NW-1:0]                   pos;
  logic [NW-1:0]                   out_cnt;
  logic                            blk_done;
  hc_pkg::sym_t                    lval;
  logic [hc_pkg::KEY_VALUE_W-1:0]  kv;
  hc_pkg::sym_t                    krem;
  logic [hc_pkg::KDIG_W-1:0]       kdig;
  logic [hc_pkg::KIDX_W-1:0]       krow;
  logic [hc_pkg::KIDX_W-1:0]       kcol;
  logic                            acc_en;
  logic                            acc_first;

  logic [NW-1:0]                   n_eff;
  logic [NW-1:0]                   lpos;
  logic                            accept;
  hc_pkg::cell_ctl_t               ctl;
  logic [PW-1:0]                   idx;
  hc_pkg::sym_t                    chain [MAX_DIM];

  // effective block size
  always_comb begin
    if (bsize == '0) begin
      n_eff = NW'(1);
    end else if (32'(bsize) > 32'(MAX_DIM)) begin
      n_eff = NW'(MAX_DIM);
    end else begin
      n_eff = NW'(bsize);
    end
  end

  assign accept = in_valid && in_ready;
  assign lpos   = (fill >= n_eff) ? '0 : fill;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hc_pkg::S_IDLE: begin
        if (accept) begin
          case (op)
            hc_pkg::OP_KEY:    state_next = hc_pkg::S_KEY;
            hc_pkg::OP_LETTER: state_next = hc_pkg::S_MUL;
            hc_pkg::OP_END: begin
              if (fill != '0 && fill < n_eff) begin
                state_next = hc_pkg::S_PAD;
              end
            end
            default: state_next = hc_pkg::S_IDLE;
          endcase
        end
      end
      hc_pkg::S_KEY: begin
        if (kdig == hc_pkg::KDIG_W'(hc_pkg::NUM_DIGITS - 1)) begin
          state_next = hc_pkg::S_KEYWR;
        end
      end
      hc_pkg::S_KEYWR: state_next = hc_pkg::S_IDLE;
      hc_pkg::S_MUL:   state_next = blk_done ? hc_pkg::S_DRAIN : hc_pkg::S_IDLE;
      hc_pkg::S_PAD: begin
        if (pos == n_eff - NW'(1)) begin
          state_next = hc_pkg::S_DRAIN;
        end
      end
      hc_pkg::S_DRAIN: state_next = hc_pkg::S_LOAD;
      hc_pkg::S_LOAD: begin
        if (out_cnt == '0) begin
          state_next = hc_pkg::S_IDLE;
        end
      end
      default: state_next = hc_pkg::S_IDLE;
    endcase
  end

  // outputs and cell controls
  always_comb begin
    ctl           = '0;
    ctl.key_row   = krow;
    ctl.key_val   = krem;
    ctl.letter    = lval;
    ctl.acc_en    = acc_en;
    ctl.acc_first = acc_first;
    in_ready      = 1'b0;
    idx           = pos[PW-1:0];
    case (state)
      hc_pkg::S_IDLE:  in_ready = 1'b1;
      hc_pkg::S_KEYWR: begin
        ctl.key_we = (32'(kcol) < 32'(MAX_DIM));
        idx        = PW'(kcol);
      end
      hc_pkg::S_MUL:   ctl.mul_en = 1'b1;
      hc_pkg::S_PAD:   ctl.mul_en = 1'b1;
      hc_pkg::S_LOAD:  ctl.load   = (out_cnt == '0);
      default:         ctl.mul_en = 1'b0;
    endcase
    out_valid   = (out_cnt != '0);
    ctl.shift   = out_valid && out_ready;
    block_last  = (out_cnt == NW'(1));
    cipher_code = hc_pkg::LETTER_W'(chain[0]) + hc_pkg::CODE_A;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= hc_pkg::S_IDLE;
      bsize   <= hc_pkg::BSIZE_W'(1);
      fill    <= '0;
      out_cnt <= '0;
      acc_en  <= 1'b0;
    end else begin
      state  <= state_next;
      acc_en <= ctl.mul_en;
      if (ctl.load) begin
        out_cnt <= n_eff;
      end else if (ctl.shift) begin
        out_cnt <= out_cnt - NW'(1);
      end
      if (accept && op == hc_pkg::OP_LETTER) begin
        fill <= (lpos + NW'(1) >= n_eff) ? '0 : lpos + NW'(1);
      end else if (accept && op == hc_pkg::OP_END) begin
        fill <= '0;
      end
      if (cfg_we) begin
        bsize <= cfg_data;
        fill  <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_first <= (state == hc_pkg::S_MUL) && (pos == '0);
    case (state)
      hc_pkg::S_IDLE: begin
        if (accept) begin
          kv   <= key_value;
          krem <= '0;
          kdig <= '0;
          krow <= key_row;
          kcol <= key_col;
          if (op == hc_pkg::OP_END) begin
            pos  <= fill;
            lval <= hc_pkg::PAD_VALUE;
          end else begin
            pos  <= lpos;
            lval <= hc_pkg::mod26(hc_pkg::RED_W'(letter_code) + hc_pkg::LETTER_OFFSET);
          end
          blk_done <= (lpos + NW'(1) >= n_eff);
        end
      end
      hc_pkg::S_KEY: begin
        krem <= hc_pkg::mod26({krem, kv[hc_pkg::KEY_VALUE_W-1 -: hc_pkg::DIGIT_W]});
        kv   <= kv << hc_pkg::DIGIT_W;
        kdig <= kdig + hc_pkg::KDIG_W'(1);
      end
      hc_pkg::S_PAD: pos <= pos + NW'(1);
      default: kdig <= kdig;
    endcase
  end

  // row of cells; cell 0 faces the output
  for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
    hc_pkg::sym_t nb;
    if (i == MAX_DIM - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = chain[i+1];
    end
    hc_cell #(
      .MAX_DIM (MAX_DIM),
      .ROW     (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (idx),
      .shift_in  (nb),
      .shift_out (chain[i])
    );
  end

`ifndef SYNTH
  // a new block only lands in the output row once the old one has left
  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> out_cnt == '0)
    else $error("block loaded over pending cipher letters");

  // every multiply is followed by its accumulate
  a_mul_acc: assert property (@(posedge clk) disable iff (rst)
    ctl.mul_en |=> acc_en)
    else $error("product not accumulated");

  // the marked letter ends the block
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && block_last) |=> !out_valid)
    else $error("output continues past last letter of block");
`endif

endmodule
